[hw/rtl/wgm_pkg.sv]
// ----------------------------------------------------------------------------
// wgm_pkg
// shared types, codes and the case folding function of the wildcard matcher
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int PATTERN_MAX_DEF = 64;

  typedef enum logic [1:0] {
    CMD_PAT  = 2'd0,
    CMD_SUBJ = 2'd1,
    CMD_END  = 2'd2,
    CMD_CLR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_ONE = 2'd1,
    KIND_ANY = 2'd2
  } kind_t;

  localparam logic [1:0] MAP_RFC    = 2'd0;
  localparam logic [1:0] MAP_STRICT = 2'd1;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } elem_t;

  typedef struct packed {
    logic load;
    logic step;
    logic restart;
  } cell_ctl_t;

  typedef struct packed {
    logic skip;
    logic adv;
  } link_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic [1:0] map);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_DELTA;
    end else if (map == MAP_RFC || map == MAP_STRICT) begin
      if (c == CH_LBRACK) r = CH_LBRACE;
      else if (c == CH_RBRACK) r = CH_RBRACE;
      else if (c == CH_BSLASH) r = CH_PIPE;
      else if (map == MAP_RFC && c == CH_TILDE) r = CH_CARET;
    end
    return r;
  endfunction

endpackage

[hw/rtl/wgm_in_if.sv]
// ----------------------------------------------------------------------------
// wgm_in_if
// command channel: command code and pattern or subject byte
// ----------------------------------------------------------------------------
interface wgm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] byte_in;

  modport source (output valid, output cmd, output byte_in, input ready);
  modport sink (input valid, input cmd, input byte_in, output ready);
endinterface

[hw/rtl/wgm_out_if.sv]
// ----------------------------------------------------------------------------
// wgm_out_if
// result channel: match flag and pattern overflow flag
// ----------------------------------------------------------------------------
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink (input valid, input matched, input overflow, output ready);
endinterface

[hw/rtl/wildcard_glob_matcher.sv]
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// case-insensitive '*' / '?' glob matcher built as a row of pattern cells
// ----------------------------------------------------------------------------
// usage: each word on req carries cmd and byte_in. cmd 0 appends a pattern
// byte, cmd 1 streams a subject byte, cmd 2 ends the subject and returns one
// word on rsp (matched, overflow), cmd 3 clears the pattern.
// a subject byte updates all cells at once, each cell handing its skip and
// advance bits to the next, so one word is taken per clock while req.ready
// is high. the result of cmd 2 is registered and shows on rsp the cycle
// after the word is taken.
// req stays ready while the result register is empty or being drained; when
// a result waits and rsp.ready is low, req.ready drops until it is taken.
// cfg_we / cfg_wdata write the case mapping (0 rfc1459, 1 strict, 2 ascii);
// the user must write it only while the block is idle (not enforced).
// reset empties the pattern, clears overflow and escape state, sets the
// mapping to rfc1459 and leaves only the first position active.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wgm_in_if.sink     req,
  wgm_out_if.source  rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [1:0]      case_map;
  logic [LW-1:0]   len;
  logic            esc;
  logic            ovf;
  logic            last_any;
  logic            tail_act;
  logic            res_valid;
  logic            res_matched;
  logic            res_ovf;

  logic            accept;
  cmd_t            cmd;
  cell_ctl_t       ctl;
  elem_t           wr_elem;
  logic            append;
  logic            full;
  logic [7:0]      sub_c;
  link_t           link [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] cur_vec;

  assign req.ready    = !res_valid || rsp.ready;
  assign accept       = req.valid && req.ready;
  assign cmd          = cmd_t'(req.cmd);
  assign full         = len >= LW'(PATTERN_MAX);
  assign sub_c        = fold_byte(req.byte_in, case_map);
  assign rsp.valid    = res_valid;
  assign rsp.matched  = res_matched;
  assign rsp.overflow = res_ovf;

  // pattern byte decode
  always_comb begin
    wr_elem.ch   = req.byte_in;
    wr_elem.kind = KIND_LIT;
    append       = 1'b0;
    if (esc) begin
      append = 1'b1;
    end else if (req.byte_in == CH_BSLASH) begin
      append = 1'b0;
    end else if (req.byte_in == CH_STAR) begin
      wr_elem.kind = KIND_ANY;
      append       = !(len != '0 && last_any);
    end else if (req.byte_in == CH_QMARK) begin
      wr_elem.kind = KIND_ONE;
      append       = 1'b1;
    end else begin
      append = 1'b1;
    end
  end

  assign ctl.load    = accept && cmd == CMD_PAT && append && !full;
  assign ctl.step    = accept && cmd == CMD_SUBJ;
  assign ctl.restart = accept && (cmd == CMD_END || cmd == CMD_CLR);

  assign link[0] = '0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wgm_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .len      (len),
      .wr_elem  (wr_elem),
      .sub_c    (sub_c),
      .map      (case_map),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .cur      (cur_vec[i])
    );
  end

  // position past the last cell
  assign cur_vec[PATTERN_MAX] = tail_act | link[PATTERN_MAX].skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_map  <= MAP_RFC;
      len       <= '0;
      esc       <= 1'b0;
      ovf       <= 1'b0;
      tail_act  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case_map <= cfg_wdata;
      end
      if (rsp.ready && !(accept && cmd == CMD_END)) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        case (cmd)
          CMD_PAT: begin
            if (esc) begin
              esc <= 1'b0;
            end else if (req.byte_in == CH_BSLASH) begin
              esc <= 1'b1;
            end
            if (append) begin
              if (full) begin
                ovf <= 1'b1;
              end else begin
                len <= len + LW'(1);
              end
            end
          end
          CMD_SUBJ: begin
            tail_act <= link[PATTERN_MAX].adv;
          end
          CMD_END: begin
            res_valid   <= 1'b1;
            res_matched <= !ovf && cur_vec[len];
            res_ovf     <= ovf;
            tail_act    <= 1'b0;
          end
          CMD_CLR: begin
            len      <= '0;
            esc      <= 1'b0;
            ovf      <= 1'b0;
            tail_act <= 1'b0;
          end
          default: begin
            tail_act <= tail_act;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last_any <= wr_elem.kind == KIND_ANY;
    end
  end

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.overflow |-> !rsp.matched)
    else $error("match reported with pattern overflow");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_CLR |=> len == '0 && !ovf && !esc)
    else $error("pattern clear incomplete");

  a_result: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_END |=> rsp.valid && cur_vec[0] && !tail_act)
    else $error("end of subject gave no result or no restart");

endmodule

[hw/rtl/wgm_cell.sv]
// ----------------------------------------------------------------------------
// wgm_cell
// one pattern element and the active bit of the position in front of it
// ----------------------------------------------------------------------------
module wgm_cell
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int IDX         = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cell_ctl_t                          ctl,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]   len,
  input  elem_t                              wr_elem,
  input  logic [7:0]                         sub_c,
  input  logic [1:0]                         map,
  input  link_t                              link_in,
  output link_t                              link_out,
  output logic                               cur
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  elem_t elem;
  logic  act;
  logic  act_next;
  logic  valid;
  logic  hit;

  assign valid = LW'(IDX) < len;
  assign cur   = act | link_in.skip;

  always_comb begin
    case (elem.kind)
      KIND_LIT: hit = fold_byte(elem.ch, map) == sub_c;
      KIND_ONE: hit = 1'b1;
      default:  hit = 1'b0;
    endcase
  end

  assign link_out.skip = cur & valid & (elem.kind == KIND_ANY);
  assign link_out.adv  = cur & valid & hit;
  assign act_next      = (cur & valid & (elem.kind == KIND_ANY)) | link_in.adv;

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      act <= (IDX == 0);
    end else if (ctl.step) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && len == LW'(IDX)) begin
      elem <= wr_elem;
    end
  end

endmodule
